// ----- rtl/fork_pair_arbiter_core_assert.svh -----
// assertion macros for the fork pair arbiter checker
`ifndef FORK_PAIR_ARBITER_CORE_ASSERT_SVH
`define FORK_PAIR_ARBITER_CORE_ASSERT_SVH

// clocked check, off while reset is low
`define FPA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also runs during reset
`define FPA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/fpa_pkg.sv -----
// shared types, codes and helper functions of the fork pair arbiter
package fpa_pkg;

	localparam int MAX_SEATS = 8;
	localparam int SEAT_W    = 3;
	localparam int CNT_W     = 4;

	typedef logic [SEAT_W-1:0]    seat_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [MAX_SEATS-1:0] map_t;
	typedef logic [1:0]           kind_t;

	localparam kind_t KIND_GRANT    = 2'd0;
	localparam kind_t KIND_ALL_FED  = 2'd1;
	localparam kind_t KIND_OVERFLOW = 2'd2;

	localparam logic OP_REQUEST = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef struct packed {
		logic clear;
		logic push;
		logic step;
		logic keep;
	} q_ctrl_t;

	// both forks of seat s in a ring of n
	function automatic map_t pair_mask(seat_t s, cnt_t n);
		cnt_t nxt;
		map_t m;
		nxt = cnt_t'(s) + cnt_t'(1);
		m = '0;
		m[s] = 1'b1;
		if (nxt >= n) begin
			m[0] = 1'b1;
		end else begin
			m[nxt[SEAT_W-1:0]] = 1'b1;
		end
		return m;
	endfunction

	// seats in use
	function automatic map_t seat_mask(cnt_t n);
		map_t m;
		for (int i = 0; i < MAX_SEATS; i++) begin
			m[i] = (cnt_t'(i) < n);
		end
		return m;
	endfunction

	function automatic cnt_t clamp_seats(cnt_t v);
		cnt_t r;
		if (v < cnt_t'(2)) begin
			r = cnt_t'(2);
		end else if (v > cnt_t'(MAX_SEATS)) begin
			r = cnt_t'(MAX_SEATS);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ----- rtl/fork_pair_arbiter_core.sv -----
// fork pair arbiter top level: fork map, fed map, control and result register
//
//  channel   dir  handshake          payload
//  s_axis    in   tvalid/tready      tuser = op, tdata[2:0] = seat
//  m_axis    out  tvalid/tready      tuser = kind, tdata[2:0] = who, tlast = last
//  cfg       in   cfg_valid/ready    cfg_data = num_seats
//
// a request's result is held in the pending register, then handed to the output register
// a release scans the waiting queue, one cell shift per entry,
// then hands its last result over when it has any
// reset and a num_seats write clear forks, fed map, queue and the finished flag
// a stalled output holds the scan only when a further result must be handed over
module fork_pair_arbiter_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [7:0]          s_axis_tdata,  // [2:0] seat
	input  logic                s_axis_tuser,  // [0] op
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [7:0]          m_axis_tdata,  // [2:0] who
	output fpa_pkg::kind_t      m_axis_tuser,  // [1:0] kind
	output logic                m_axis_tlast,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  fpa_pkg::cnt_t       cfg_data
);
	import fpa_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic [1:0] state_q;
	cnt_t       nseat_q;
	map_t       fork_free_q;
	map_t       fed_q;
	logic       finished_q;
	cnt_t       remain_q;
	logic [1:0] grants_q;
	logic       pend_vld_q;
	kind_t      pend_kind_q;
	seat_t      pend_who_q;
	logic       out_vld_q;
	kind_t      out_kind_q;
	seat_t      out_who_q;
	logic       out_last_q;

	q_ctrl_t qc;
	seat_t   head;
	cnt_t    qcount;

	seat_t in_seat;
	logic  in_fire;
	logic  cfg_fire;
	logic  out_free;
	logic  in_live;
	map_t  in_mask;
	logic  in_pair_free;
	map_t  head_mask;
	logic  head_ok;
	logic  scan_busy;
	logic  step;
	logic  all_fed;
	logic  push_out;
	logic  push_last;

	assign in_seat      = s_axis_tdata[SEAT_W-1:0];
	assign in_fire      = s_axis_tvalid && s_axis_tready;
	assign cfg_fire     = cfg_valid && cfg_ready;
	assign out_free     = !out_vld_q || m_axis_tready;
	assign in_live      = !finished_q && (cnt_t'(in_seat) < nseat_q);
	assign in_mask      = pair_mask(in_seat, nseat_q);
	assign in_pair_free = (fork_free_q & in_mask) == in_mask;
	assign head_mask    = pair_mask(head, nseat_q);
	assign head_ok      = (cnt_t'(head) < nseat_q) && (grants_q < 2'd2)
		&& ((fork_free_q & head_mask) == head_mask);
	assign scan_busy    = (state_q == ST_SCAN) && (remain_q != '0);
	assign step         = scan_busy && !(head_ok && pend_vld_q && !out_free);
	assign all_fed      = (fed_q | ~seat_mask(nseat_q)) == '1;

	assign qc.clear = cfg_fire;
	assign qc.push  = (state_q == ST_IDLE) && in_fire && in_live
		&& (s_axis_tuser == OP_REQUEST) && !in_pair_free
		&& (qcount != cnt_t'(MAX_SEATS));
	assign qc.step  = step;
	assign qc.keep  = !head_ok;

	fpa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (qc),
		.push_seat (in_seat),
		.head      (head),
		.count     (qcount)
	);

	// hand the held result to the output register
	always_comb begin
		push_out  = 1'b0;
		push_last = 1'b0;
		unique case (state_q)
			ST_FLUSH: begin
				push_out  = out_free;
				push_last = 1'b1;
			end
			ST_SCAN: begin
				if (remain_q != '0) begin
					push_out = step && head_ok && pend_vld_q;
				end else begin
					push_out = all_fed && pend_vld_q && out_free;
				end
			end
			default: begin
				push_out = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			nseat_q     <= cnt_t'(MAX_SEATS);
			fork_free_q <= '1;
			fed_q       <= '0;
			finished_q  <= 1'b0;
			remain_q    <= '0;
			grants_q    <= '0;
			pend_vld_q  <= 1'b0;
			pend_kind_q <= KIND_GRANT;
			pend_who_q  <= '0;
			out_vld_q   <= 1'b0;
			out_kind_q  <= KIND_GRANT;
			out_who_q   <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (push_out) begin
				out_vld_q  <= 1'b1;
				out_kind_q <= pend_kind_q;
				out_who_q  <= pend_who_q;
				out_last_q <= push_last;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end

			if (cfg_fire) begin
				nseat_q     <= clamp_seats(cfg_data);
				fork_free_q <= '1;
				fed_q       <= '0;
				finished_q  <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_fire && in_live) begin
						if (s_axis_tuser == OP_REQUEST) begin
							if (in_pair_free) begin
								fork_free_q <= fork_free_q & ~in_mask;
								pend_vld_q  <= 1'b1;
								pend_kind_q <= KIND_GRANT;
								pend_who_q  <= in_seat;
								state_q     <= ST_FLUSH;
							end else if (qcount == cnt_t'(MAX_SEATS)) begin
								pend_vld_q  <= 1'b1;
								pend_kind_q <= KIND_OVERFLOW;
								pend_who_q  <= in_seat;
								state_q     <= ST_FLUSH;
							end
						end else begin
							fork_free_q     <= fork_free_q | in_mask;
							fed_q[in_seat]  <= 1'b1;
							remain_q        <= qcount;
							grants_q        <= '0;
							state_q         <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (remain_q != '0) begin
						if (step) begin
							remain_q <= remain_q - cnt_t'(1);
							if (head_ok) begin
								fork_free_q <= fork_free_q & ~head_mask;
								grants_q    <= grants_q + 2'd1;
								pend_vld_q  <= 1'b1;
								pend_kind_q <= KIND_GRANT;
								pend_who_q  <= head;
							end
						end
					end else if (all_fed) begin
						if (!pend_vld_q || out_free) begin
							finished_q  <= 1'b1;
							pend_vld_q  <= 1'b1;
							pend_kind_q <= KIND_ALL_FED;
							pend_who_q  <= '0;
							state_q     <= ST_FLUSH;
						end
					end else begin
						state_q <= pend_vld_q ? ST_FLUSH : ST_IDLE;
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						pend_vld_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {{(8-SEAT_W){1'b0}}, out_who_q};
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

endmodule

// ----- rtl/fpa_cell.sv -----
// one wait queue cell: holds a seat, takes its neighbor's seat on a shift
module fpa_cell (
	input  logic          clk,
	input  logic          shift,
	input  logic          load,
	input  fpa_pkg::seat_t load_val,
	input  fpa_pkg::seat_t next_val,
	output fpa_pkg::seat_t val
);
	import fpa_pkg::*;

	seat_t val_q;

	always_ff @(posedge clk) begin
		if (load) begin
			val_q <= load_val;
		end else if (shift) begin
			val_q <= next_val;
		end
	end

	assign val = val_q;

endmodule

// ----- rtl/fpa_queue.sv -----
// wait queue built as a row of cells that shifts one entry per scan step, a kept head going to the tail
module fpa_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  fpa_pkg::q_ctrl_t ctrl,
	input  fpa_pkg::seat_t   push_seat,
	output fpa_pkg::seat_t   head,
	output fpa_pkg::cnt_t    count
);
	import fpa_pkg::*;

	cnt_t  count_q;
	seat_t cell_val [MAX_SEATS];
	seat_t tail_idx;
	seat_t push_idx;
	cnt_t  tail_cnt;

	assign tail_cnt = count_q - cnt_t'(1);
	assign tail_idx = tail_cnt[SEAT_W-1:0];
	assign push_idx = count_q[SEAT_W-1:0];

	for (genvar i = 0; i < MAX_SEATS; i++) begin : g_cell
		logic  ld;
		seat_t ld_val;
		seat_t nx_val;

		assign ld = (ctrl.push && push_idx == seat_t'(i))
			|| (ctrl.step && ctrl.keep && tail_idx == seat_t'(i));
		assign ld_val = ctrl.push ? push_seat : cell_val[0];

		if (i == MAX_SEATS - 1) begin : g_end
			assign nx_val = cell_val[i];
		end else begin : g_mid
			assign nx_val = cell_val[i+1];
		end

		fpa_cell u_cell (
			.clk      (clk),
			.shift    (ctrl.step),
			.load     (ld),
			.load_val (ld_val),
			.next_val (nx_val),
			.val      (cell_val[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.clear) begin
			count_q <= '0;
		end else if (ctrl.push) begin
			count_q <= count_q + cnt_t'(1);
		end else if (ctrl.step && !ctrl.keep) begin
			count_q <= count_q - cnt_t'(1);
		end
	end

	assign head  = cell_val[0];
	assign count = count_q;

endmodule

// ----- rtl/fpa_checker.sv -----
// port level checks of the fork pair arbiter, bound to the top level
`include "fork_pair_arbiter_core_assert.svh"

module fpa_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           s_axis_tvalid,
	input logic           s_axis_tready,
	input logic [7:0]     s_axis_tdata,
	input logic           s_axis_tuser,
	input logic           m_axis_tvalid,
	input logic           m_axis_tready,
	input logic [7:0]     m_axis_tdata,
	input fpa_pkg::kind_t m_axis_tuser,
	input logic           m_axis_tlast,
	input logic           cfg_valid,
	input logic           cfg_ready,
	input fpa_pkg::cnt_t  cfg_data
);
	import fpa_pkg::*;

	// stalled result holds
	`FPA_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result changed while stalled")

	// config is only taken while the block takes items
	`FPA_ASSERT_ALWAYS(a_cfg_idle, cfg_valid && cfg_ready |-> s_axis_tready, "config transfer while busy")

	// all fed closes its item and names seat zero
	`FPA_ASSERT(a_fed_last, m_axis_tvalid && m_axis_tuser == KIND_ALL_FED |-> m_axis_tlast && m_axis_tdata == 8'd0, "all fed result malformed")

	// overflow is the only result of its request
	`FPA_ASSERT(a_ovf_last, m_axis_tvalid && m_axis_tuser == KIND_OVERFLOW |-> m_axis_tlast, "overflow not last")

	// an item is taken only when no result is being built
	`FPA_ASSERT(a_in_quiet, s_axis_tvalid && s_axis_tready |-> cfg_ready, "input taken while busy")

endmodule

bind fork_pair_arbiter_core fpa_checker u_fpa_checker (.*);
